FILE: rtl/bvs_pkg.sv
// Shared types, constants and register indexes for the button volume stepper.
`default_nettype none

package bvs_pkg;

    // Field widths
    localparam int LEVEL_W    = 5;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd2;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0]    MAX_GAIN_RST = 5'd31;
    localparam logic [INTERVAL_W-1:0] REPEAT_RST   = 16'd100;
    localparam logic [INTERVAL_W-1:0] SETTLE_RST   = 16'd1000;

    // One poll tick
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              phones_in;
        logic              down_pressed;
        logic              up_pressed;
    } item_t;

    // One result of a poll tick
    typedef struct packed {
        logic [LEVEL_W-1:0] volume_goal;
        logic [LEVEL_W-1:0] volume_now;
        logic [LEVEL_W-1:0] save_value;
        logic               save_now;
        logic               step_down;
        logic               step_up;
    } result_t;

    // Configuration register set
    typedef struct packed {
        logic [LEVEL_W-1:0]    max_gain;
        logic [INTERVAL_W-1:0] repeat_interval_ms;
        logic [INTERVAL_W-1:0] settle_interval_ms;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/bvs_cfg_regs.sv
// Configuration register file written through the plain write port.
`default_nettype none

module bvs_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output bvs_pkg::cfg_t                       cfg
);
    import bvs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; writes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_GAIN: cfg_next.max_gain           = cfg_wdata[LEVEL_W-1:0];
                REG_REPEAT:   cfg_next.repeat_interval_ms = cfg_wdata[INTERVAL_W-1:0];
                REG_SETTLE:   cfg_next.settle_interval_ms = cfg_wdata[INTERVAL_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_gain           <= MAX_GAIN_RST;
            cfg_reg.repeat_interval_ms <= REPEAT_RST;
            cfg_reg.settle_interval_ms <= SETTLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/bvs_in_reg.sv
// Input register stage that holds one accepted poll tick.
`default_nettype none

module bvs_in_reg (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  bvs_pkg::item_t in_item,
    input  wire logic   take,
    output logic        item_valid,
    output bvs_pkg::item_t item
);
    import bvs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage refills in the same cycle that its item moves on.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: rtl/bvs_step.sv
// Volume state and the per-tick update of target, current level and save request.
`default_nettype none

module bvs_step (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  bvs_pkg::cfg_t   cfg,
    input  wire logic       item_valid,
    input  bvs_pkg::item_t  item,
    input  wire logic       out_ready,
    output logic            fire,
    output bvs_pkg::result_t result
);
    import bvs_pkg::*;

    logic [LEVEL_W-1:0] current_reg, current_next;
    logic [LEVEL_W-1:0] target_reg,  target_next;
    logic [LEVEL_W-1:0] parked_reg,  parked_next;
    logic [LEVEL_W-1:0] stored_reg,  stored_next;
    logic               prev_up_reg, prev_up_next;
    logic               prev_down_reg, prev_down_next;
    logic               prev_phones_reg, prev_phones_next;
    logic [TIME_W-1:0]  up_time_reg, up_time_next;
    logic [TIME_W-1:0]  down_time_reg, down_time_next;

    logic [TIME_W-1:0]  up_elapsed;
    logic [TIME_W-1:0]  down_elapsed;
    logic [TIME_W-1:0]  up_quiet;
    logic [TIME_W-1:0]  down_quiet;
    logic [TIME_W-1:0]  repeat_ext;
    logic [TIME_W-1:0]  settle_ext;

    logic               step_up;
    logic               step_down;
    logic               save_now;
    logic [LEVEL_W-1:0] save_value;

    assign fire = item_valid && out_ready;

    assign repeat_ext   = {{(TIME_W-INTERVAL_W){1'b0}}, cfg.repeat_interval_ms};
    assign settle_ext   = {{(TIME_W-INTERVAL_W){1'b0}}, cfg.settle_interval_ms};
    assign up_elapsed   = item.now_ms - up_time_reg;
    assign down_elapsed = item.now_ms - down_time_reg;
    assign up_quiet     = item.now_ms - up_time_next;
    assign down_quiet   = item.now_ms - down_time_next;

    // Headphone edge, button steps, then one volume step toward the target.
    always_comb
    begin
        target_next      = target_reg;
        parked_next      = parked_reg;
        prev_phones_next = prev_phones_reg;
        prev_up_next     = prev_up_reg;
        prev_down_next   = prev_down_reg;
        up_time_next     = up_time_reg;
        down_time_next   = down_time_reg;
        current_next     = current_reg;
        step_up          = 1'b0;
        step_down        = 1'b0;

        // Plugging in parks the target; unplugging restores it within the gain limit.
        if (item.phones_in != prev_phones_reg)
        begin
            prev_phones_next = item.phones_in;
            if (item.phones_in)
            begin
                parked_next = target_reg;
                target_next = '0;
            end
            else
            begin
                target_next = (parked_reg > cfg.max_gain) ? cfg.max_gain : parked_reg;
            end
        end

        // Up button: edge or held past the repeat interval.
        if ((item.up_pressed != prev_up_reg) || (up_elapsed > repeat_ext))
        begin
            if (item.up_pressed && (target_next < cfg.max_gain))
            begin
                target_next  = target_next + 1'b1;
                up_time_next = item.now_ms;
            end
            prev_up_next = item.up_pressed;
        end

        // Down button: same rule, toward zero.
        if ((item.down_pressed != prev_down_reg) || (down_elapsed > repeat_ext))
        begin
            if (item.down_pressed && (target_next != '0))
            begin
                target_next    = target_next - 1'b1;
                down_time_next = item.now_ms;
            end
            prev_down_next = item.down_pressed;
        end

        // A rising step is skipped while the volume sits above a lowered gain limit.
        if (target_next > current_reg)
        begin
            if (current_reg <= cfg.max_gain)
            begin
                current_next = current_reg + 1'b1;
                step_up      = 1'b1;
            end
        end
        else if (target_next < current_reg)
        begin
            current_next = current_reg - 1'b1;
            step_down    = 1'b1;
        end
    end

    // Save once settled, unplugged, quiet on both buttons and changed.
    always_comb
    begin
        stored_next = stored_reg;
        save_now    = 1'b0;
        save_value  = '0;
        if (!item.phones_in && (current_next == target_next) &&
            (stored_reg != current_next) &&
            (up_quiet > settle_ext) && (down_quiet > settle_ext))
        begin
            stored_next = current_next;
            save_now    = 1'b1;
            save_value  = current_next;
        end
    end

    // Result word of this tick, lowest field last.
    assign result = {target_next, current_next, save_value, save_now, step_down, step_up};

    // State advances only with a transaction that moves a result out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg     <= '0;
            target_reg      <= '0;
            parked_reg      <= '0;
            stored_reg      <= '0;
            prev_up_reg     <= 1'b0;
            prev_down_reg   <= 1'b0;
            prev_phones_reg <= 1'b0;
            up_time_reg     <= '0;
            down_time_reg   <= '0;
        end
        else if (fire)
        begin
            current_reg     <= current_next;
            target_reg      <= target_next;
            parked_reg      <= parked_next;
            stored_reg      <= stored_next;
            prev_up_reg     <= prev_up_next;
            prev_down_reg   <= prev_down_next;
            prev_phones_reg <= prev_phones_next;
            up_time_reg     <= up_time_next;
            down_time_reg   <= down_time_next;
        end
    end

`ifndef SYNTH
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(result.step_up && result.step_down))
        else $error("volume stepped up and down in one tick");

    a_level_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(current_reg) && $stable(target_reg) && $stable(stored_reg))
        else $error("volume state changed without a transaction");

    a_save_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.save_now) |=> (stored_reg == current_reg))
        else $error("stored level does not follow the saved volume");

    a_save_unplugged: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.save_now) |-> !item.phones_in)
        else $error("save requested while plugged in");
`endif

endmodule

`default_nettype wire

FILE: rtl/bvs_out_reg.sv
// Result register stage that holds one result until the consumer takes it.
`default_nettype none

module bvs_out_reg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  bvs_pkg::result_t result_in,
    output logic             can_load,
    output logic             out_valid,
    input  wire logic        out_ready,
    output bvs_pkg::result_t result_out
);
    import bvs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // A new result may enter as the held one leaves.
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = can_load ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

FILE: rtl/button_volume_stepper_core.sv
// Path: a tick accepted into the input register is worked on by the step logic, and
// its result is held in the result register and presented on the master side.
// Throughput: one tick per cycle while the master side takes results; the volume update
// is one pass of short logic between the input register and the result register.
// Reset: asynchronous, active low; levels, step times and flags clear to zero,
// and the configuration returns to max gain 31, repeat 100 ms and settle 1000 ms.
`default_nettype none

module button_volume_stepper_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // up_pressed, down_pressed, phones_in, now_ms[31:0], zero fill
    input  wire logic [bvs_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // step_up, step_down, save_now, save_value[4:0], volume_now[4:0],
    // volume_goal[4:0], zero fill
    output logic [bvs_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [bvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bvs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bvs_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    logic    can_load;
    result_t result;
    result_t result_out;

    // Unpack the slave-side data word.
    assign in_item.up_pressed   = s_tdata[0];
    assign in_item.down_pressed = s_tdata[1];
    assign in_item.phones_in    = s_tdata[2];
    assign in_item.now_ms       = s_tdata[TIME_W+2:3];

    bvs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bvs_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    bvs_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (can_load),
        .fire       (fire),
        .result     (result)
    );

    bvs_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result_in  (result),
        .can_load   (can_load),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result_out (result_out)
    );

    // Pack the master-side data word, lowest field last.
    assign m_tdata = {{(OUT_DATA_W-3-3*LEVEL_W){1'b0}},
                      result_out.volume_goal,
                      result_out.volume_now,
                      result_out.save_value,
                      result_out.save_now,
                      result_out.step_down,
                      result_out.step_up};

endmodule

`default_nettype wire

FILE: tb/button_volume_stepper_core_tb.sv
// Self-checking testbench for the button volume stepper core.
`timescale 1ns / 100ps

module button_volume_stepper_core_tb;

    import bvs_pkg::*;

    localparam int ITEM_BITS   = $bits(item_t);
    localparam int RESULT_BITS = $bits(result_t);
    localparam int CYCLE_LIMIT = 100000;
    localparam int LONG_STALL  = 60;

    // Index beyond the register map; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Predicts the result of every accepted tick and checks what comes out.
    class volume_scoreboard;
        logic [LEVEL_W-1:0]    max_gain;
        logic [INTERVAL_W-1:0] repeat_ms;
        logic [INTERVAL_W-1:0] settle_ms;
        logic [LEVEL_W-1:0]    level;
        logic [LEVEL_W-1:0]    goal;
        logic [LEVEL_W-1:0]    parked;
        logic [LEVEL_W-1:0]    stored;
        logic                  prev_up;
        logic                  prev_down;
        logic                  prev_phones;
        logic [TIME_W-1:0]     up_time;
        logic [TIME_W-1:0]     down_time;
        result_t               expected_results[$];
        int                    errors;

        function new();
            max_gain    = MAX_GAIN_RST;
            repeat_ms   = REPEAT_RST;
            settle_ms   = SETTLE_RST;
            level       = '0;
            goal        = '0;
            parked      = '0;
            stored      = '0;
            prev_up     = 1'b0;
            prev_down   = 1'b0;
            prev_phones = 1'b0;
            up_time     = '0;
            down_time   = '0;
            errors      = 0;
        endfunction

        // Register writes are masked to the register widths.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MAX_GAIN: max_gain  = value[LEVEL_W-1:0];
                REG_REPEAT:   repeat_ms = value;
                REG_SETTLE:   settle_ms = value;
                default:      ;
            endcase
        endfunction

        // Advances the volume state by one poll tick and queues the expected result.
        function void note_tick(item_t tick);
            result_t           res;
            logic [TIME_W-1:0] up_gap;
            logic [TIME_W-1:0] down_gap;
            res = '0;

            // Headphone edges park or restore the target.
            if (tick.phones_in != prev_phones) begin
                prev_phones = tick.phones_in;
                if (tick.phones_in) begin
                    parked = goal;
                    goal   = '0;
                end else begin
                    goal = (parked > max_gain) ? max_gain : parked;
                end
            end

            // Up button first, then the down button.
            up_gap = tick.now_ms - up_time;
            if (tick.up_pressed != prev_up || up_gap > TIME_W'(repeat_ms)) begin
                if (tick.up_pressed && goal < max_gain) begin
                    goal    = goal + 1'b1;
                    up_time = tick.now_ms;
                end
                prev_up = tick.up_pressed;
            end
            down_gap = tick.now_ms - down_time;
            if (tick.down_pressed != prev_down || down_gap > TIME_W'(repeat_ms)) begin
                if (tick.down_pressed && goal != '0) begin
                    goal      = goal - 1'b1;
                    down_time = tick.now_ms;
                end
                prev_down = tick.down_pressed;
            end

            // The amplifier moves one step toward the target; a rising step is skipped above max gain.
            if (goal > level) begin
                if (level <= max_gain) begin
                    level       = level + 1'b1;
                    res.step_up = 1'b1;
                end
            end else if (goal < level) begin
                level         = level - 1'b1;
                res.step_down = 1'b1;
            end

            // A settled, quiet volume that differs from the stored one gets saved.
            up_gap   = tick.now_ms - up_time;
            down_gap = tick.now_ms - down_time;
            if (!tick.phones_in && level == goal && stored != level &&
                up_gap > TIME_W'(settle_ms) && down_gap > TIME_W'(settle_ms)) begin
                stored         = level;
                res.save_now   = 1'b1;
                res.save_value = level;
            end

            res.volume_now  = level;
            res.volume_goal = goal;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compares one result transaction with the oldest expectation.
        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result transaction %h arrived with no tick outstanding", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("step_up", 32'(want.step_up), 32'(got.step_up));
            compare_field("step_down", 32'(want.step_down), 32'(got.step_down));
            compare_field("save_now", 32'(want.save_now), 32'(got.save_now));
            compare_field("save_value", 32'(want.save_value), 32'(got.save_value));
            compare_field("volume_now", 32'(want.volume_now), 32'(got.volume_now));
            compare_field("volume_goal", 32'(want.volume_goal), 32'(got.volume_goal));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // up_pressed, down_pressed, phones_in, now_ms[31:0], zero fill
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // step_up, step_down, save_now, save_value[4:0], volume_now[4:0],
    // volume_goal[4:0], zero fill
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    volume_scoreboard scoreboard = new();

    logic [TIME_W-1:0] clock_ms;
    logic              phones_level;
    logic              calm;
    int unsigned       repeat_set;
    int unsigned       settle_set;
    int                ticks_sent;
    int                holds_asked;
    int                holds_taken;
    int                stall_left;
    int                cycles;

    button_volume_stepper_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("button_volume_stepper_core verification failed");
            $finish;
        end
    end

    // Both sides are sampled at the same edge; ticks are noted before results are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                scoreboard.note_tick(item_t'(s_tdata[ITEM_BITS-1:0]));
            if (m_tvalid && m_tready)
                scoreboard.check_result(result_t'(m_tdata[RESULT_BITS-1:0]));
        end
    end

    // Result receiver: random stalls per transaction, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (holds_taken != holds_asked)
        begin
            holds_taken = holds_asked;
            stall_left  = LONG_STALL;
            m_tready   <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            stall_left = calm ? 0 : $urandom_range(0, 4);
            m_tready  <= (stall_left == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready  <= (stall_left == 0);
        end
        else
            m_tready <= 1'b1;
    end

    // Offers one poll tick and waits for its transaction.
    task automatic send_tick(input logic up, input logic dn, input logic ph,
                             input logic [TIME_W-1:0] adv);
        item_t tick;
        int    gap;
        clock_ms          = clock_ms + adv;
        tick.up_pressed   = up;
        tick.down_pressed = dn;
        tick.phones_in    = ph;
        tick.now_ms       = clock_ms;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - ITEM_BITS){1'b0}}, tick};
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
    endtask

    // Stops offering ticks until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (scoreboard.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        scoreboard.write_reg(idx, value);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] gain_word,
                                  input logic [CFG_DATA_W-1:0] repeat_word,
                                  input logic [CFG_DATA_W-1:0] settle_word);
        write_reg(REG_MAX_GAIN, gain_word);
        write_reg(REG_REPEAT, repeat_word);
        write_reg(REG_SETTLE, settle_word);
        cfg_we     <= 1'b0;
        repeat_set  = 32'(repeat_word);
        settle_set  = 32'(settle_word);
    endtask

    // One random user action: taps, holds, plugging, quiet spells, noise or clock jumps.
    task automatic play_gesture();
        int   kind;
        int   n;
        logic pick_up;
        logic other;
        kind    = $urandom_range(0, 9);
        calm    = ($urandom_range(0, 3) == 0);
        pick_up = 1'($urandom_range(0, 1));
        case (kind)
            0, 1, 2:
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_tick(pick_up, !pick_up, phones_level, $urandom_range(0, 60));
                send_tick(1'b0, 1'b0, phones_level, $urandom_range(0, 60));
            end
            3, 4:
            begin
                n     = $urandom_range(3, 15);
                other = ($urandom_range(0, 3) == 0);
                repeat (n)
                    send_tick(pick_up | other, !pick_up | other, phones_level,
                              $urandom_range(0, repeat_set + 30));
                send_tick(1'b0, 1'b0, phones_level, $urandom_range(0, 20));
            end
            5:
            begin
                phones_level = !phones_level;
                n = $urandom_range(1, 3);
                repeat (n)
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              phones_level, $urandom_range(0, 50));
            end
            6, 7:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_tick(1'b0, 1'b0, phones_level,
                              $urandom_range(0, settle_set + settle_set / 2 + 50));
            end
            8:
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    phones_level = 1'($urandom_range(0, 1));
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              phones_level, $urandom_range(0, 200));
                end
            end
            default:
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          phones_level, $urandom);
        endcase
    endtask

    task automatic run_ticks(input int count);
        int stop_at;
        stop_at = ticks_sent + count;
        while (ticks_sent < stop_at)
            play_gesture();
    endtask

    // Register settings of each random phase, extremes first.
    task automatic setup_phase(input int phase);
        case (phase)
            1: apply_settings(16'd31, 16'd0, 16'd0);
            2: apply_settings(16'd0, 16'hFFFF, 16'hFFFF);
            3:
            begin
                write_reg(REG_SPARE, 16'($urandom_range(0, 16'hFFFF)));
                apply_settings(16'hFFE7, 16'd40, 16'd300);
            end
            4: apply_settings(16'd17, 16'd1, 16'hFFFF);
            5: apply_settings(16'd31, 16'hFFFF, 16'd0);
            6: apply_settings(16'd3, 16'd250, 16'd50);
            default:
                apply_settings(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 300)),
                               16'($urandom_range(0, 3000)));
        endcase
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        clock_ms     = '0;
        phones_level = 1'b0;
        calm         = 1'b0;
        repeat_set   = 32'(REPEAT_RST);
        settle_set   = 32'(SETTLE_RST);
        ticks_sent   = 0;
        holds_asked  = 0;
        holds_taken  = 0;
        stall_left   = 0;
        cycles       = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks with the reset settings: edges, repeats, floor, plugging, saves, wrap.
        send_tick(1'b0, 1'b0, 1'b0, 5);
        send_tick(1'b1, 1'b0, 1'b0, 5);
        send_tick(1'b1, 1'b0, 1'b0, 40);
        send_tick(1'b1, 1'b0, 1'b0, 101);
        send_tick(1'b0, 1'b0, 1'b0, 1);
        send_tick(1'b0, 1'b1, 1'b0, 8);
        send_tick(1'b1, 1'b1, 1'b0, 10);
        send_tick(1'b0, 1'b1, 1'b0, 5);
        send_tick(1'b0, 1'b1, 1'b0, 125);
        send_tick(1'b0, 1'b1, 1'b0, 120);
        send_tick(1'b0, 1'b1, 1'b0, 120);
        send_tick(1'b0, 1'b0, 1'b0, 5);
        repeat (3)
        begin
            send_tick(1'b1, 1'b0, 1'b0, 2);
            send_tick(1'b0, 1'b0, 1'b0, 2);
        end
        send_tick(1'b0, 1'b0, 1'b1, 5);
        send_tick(1'b1, 1'b0, 1'b1, 5);
        send_tick(1'b0, 1'b0, 1'b0, 5);
        send_tick(1'b0, 1'b0, 1'b0, 2000);
        send_tick(1'b0, 1'b0, 1'b0, 2000);
        send_tick(1'b0, 1'b0, 1'b0, 32'hFFFF_F000);
        send_tick(1'b1, 1'b0, 1'b0, 32'h0000_1FFF);
        drain();

        // Raise the target high, leave the volume low, then lower max gain under it.
        apply_settings(16'd31, 16'd0, 16'd20);
        repeat (12) send_tick(1'b1, 1'b0, 1'b0, 1);
        repeat (14) send_tick(1'b0, 1'b0, 1'b1, 1);
        send_tick(1'b0, 1'b0, 1'b0, 1);
        drain();
        apply_settings(16'hFFE5, 16'd0, 16'd20);
        repeat (8) send_tick(1'b0, 1'b0, 1'b0, 5);
        send_tick(1'b1, 1'b0, 1'b0, 5);
        send_tick(1'b0, 1'b1, 1'b0, 5);
        send_tick(1'b0, 1'b0, 1'b0, 100);
        phones_level = 1'b0;
        drain();

        // Random phases, each under its own register settings.
        for (int phase = 1; phase <= 8; phase++)
        begin
            setup_phase(phase);
            if (phase == 2)
                holds_asked++;
            if (phase == 4)
            begin
                run_ticks(50);
                drain();
                run_ticks(50);
            end
            else
                run_ticks(100);
            drain();
        end

        repeat (8) @(posedge clk);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("button_volume_stepper_core verification clean");
        else
            $display("button_volume_stepper_core verification failed");
        $finish;
    end

endmodule
